// ===== rtl/acg_pkg.sv =====
// Package: shared widths, constants, state codes and control structs for the compressor.
package acg_pkg;

   // Field widths
   localparam int SAMPLE_W = 24;
   localparam int LEVEL_W  = 24;
   localparam int THR_W    = 23;
   localparam int GAIN_W   = 24;
   localparam int RATIO_W  = 18;
   localparam int COEF_W   = 25;
   localparam int ENV_W    = 32;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 25;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_MAKEUP    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_INV_RATIO = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_OUT_GAIN  = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_ATTACK    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_RELEASE   = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_GATE      = 3'd6;

   // Register reset values
   localparam logic [THR_W-1:0]   THRESHOLD_RST = 23'd525493;
   localparam logic [GAIN_W-1:0]  MAKEUP_RST    = 24'd65536;
   localparam logic [RATIO_W-1:0] INV_RATIO_RST = 18'd65536;
   localparam logic [GAIN_W-1:0]  OUT_GAIN_RST  = 24'd73532;
   localparam logic [COEF_W-1:0]  ATTACK_RST    = 25'd69760;
   localparam logic [COEF_W-1:0]  RELEASE_RST   = 25'd1748;
   localparam logic [THR_W-1:0]   GATE_RST      = 23'd10486;

   // Arithmetic constants
   localparam logic [LEVEL_W-1:0] PEAK_FLOOR     = 24'd283399;
   localparam logic [36:0]        TARGET_CAP     = 37'd104857600000;
   localparam logic [ENV_W-1:0]   ENV_CAP        = 32'd3276800000;
   localparam logic [ENV_W-1:0]   ENV_ONE        = 32'd32768;
   localparam logic [21:0]        GATE_DOWN      = 22'd3355443;
   localparam logic [21:0]        GATE_UP        = 22'd1677722;
   localparam logic [23:0]        GATE_OPEN_FRAC = 24'd9730785;
   localparam logic [COEF_W-1:0]  COEF_ONE       = 25'd16777216;
   localparam logic [RATIO_W-1:0] UNITY_RATIO    = 18'd65536;

   // Divider geometry: 32 quotient bits, four per cycle
   localparam int QUO_W          = 32;
   localparam int DIV_BITS       = 4;
   localparam int DIV_STEPS      = QUO_W / DIV_BITS;
   localparam int DIV_CNT_W      = $clog2(DIV_STEPS);

   // Sequencer states
   typedef enum logic [10:0] {
      S_IDLE    = 11'b000_0000_0001,
      S_LEVEL   = 11'b000_0000_0010,
      S_TARGET  = 11'b000_0000_0100,
      S_GATE    = 11'b000_0000_1000,
      S_DIVLOAD = 11'b000_0001_0000,
      S_DIV     = 11'b000_0010_0000,
      S_ENVMUL  = 11'b000_0100_0000,
      S_ENVUPD  = 11'b000_1000_0000,
      S_GAIN    = 11'b001_0000_0000,
      S_SCALE   = 11'b010_0000_0000,
      S_FINISH  = 11'b100_0000_0000
   } acg_state_type;

   // Commands from controller to datapath
   typedef struct packed {
      logic capture;
      logic level;
      logic target;
      logic gate;
      logic div_load;
      logic div_step;
      logic env_mul;
      logic env_upd;
      logic gain;
      logic scale;
      logic finish;
   } acg_cmd_type;

   // Status from datapath to controller
   typedef struct packed {
      logic bypass;
   } acg_status_type;

   // Magnitude of a two's complement sample
   function automatic logic [LEVEL_W-1:0] magnitude(input logic [SAMPLE_W-1:0] v);
      magnitude = v[SAMPLE_W-1] ? (~v + 24'd1) : v;
   endfunction

endpackage

// ===== rtl/acg_if.sv =====
// Interfaces: valid/ready channels for input frames and result frames.
interface acg_req_if;
   logic        valid;
   logic        ready;
   logic [23:0] sample_left;
   logic [23:0] sample_right;
   modport source (output valid, output sample_left, output sample_right, input ready);
   modport sink (input valid, input sample_left, input sample_right, output ready);
endinterface

interface acg_rsp_if;
   logic        valid;
   logic        ready;
   logic [23:0] out_left;
   logic [23:0] out_right;
   modport source (output valid, output out_left, output out_right, input ready);
   modport sink (input valid, input out_left, input out_right, output ready);
endinterface

// ===== rtl/acg_controller.sv =====
// Controller: sequences one frame through the datapath and owns the result valid flag.
module acg_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  acg_pkg::acg_status_type status,
   output acg_pkg::acg_cmd_type    cmd
);
   import acg_pkg::*;

   acg_state_type          state_ff, state_in;
   logic [DIV_CNT_W-1:0]   div_cnt_ff, div_cnt_in;
   logic                   out_valid_ff, out_valid_in;
   logic                   accept;
   logic                   out_free;

   assign req_ready = (state_ff == S_IDLE);
   assign accept    = req_valid && req_ready;
   assign out_free  = !out_valid_ff || rsp_ready;
   assign rsp_valid = out_valid_ff;

   // Next state and commands
   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               cmd.capture = 1'b1;
               state_in = status.bypass ? S_FINISH : S_LEVEL;
            end
         end
         S_LEVEL: begin
            cmd.level = 1'b1;
            state_in  = S_TARGET;
         end
         S_TARGET: begin
            cmd.target = 1'b1;
            state_in   = S_GATE;
         end
         S_GATE: begin
            cmd.gate = 1'b1;
            state_in = S_DIVLOAD;
         end
         S_DIVLOAD: begin
            cmd.div_load = 1'b1;
            div_cnt_in   = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            div_cnt_in   = div_cnt_ff + DIV_CNT_W'(1);
            if (div_cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
               state_in = S_ENVMUL;
            end
         end
         S_ENVMUL: begin
            cmd.env_mul = 1'b1;
            state_in    = S_ENVUPD;
         end
         S_ENVUPD: begin
            cmd.env_upd = 1'b1;
            state_in    = S_GAIN;
         end
         S_GAIN: begin
            cmd.gain = 1'b1;
            state_in = S_SCALE;
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   // Result valid: set on load, drop when taken
   always_comb begin
      out_valid_in = out_valid_ff;
      if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
      if (cmd.finish) begin
         out_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         div_cnt_ff   <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         div_cnt_ff   <= div_cnt_in;
         out_valid_ff <= out_valid_in;
      end
   end

endmodule

// ===== rtl/acg_datapath.sv =====
// Datapath: registers, gate floor, envelope, divider and sample scaling.
module acg_datapath #(
   parameter logic [24:0] PEAK_ATTACK_COEFF  = 25'd353,
   parameter logic [24:0] PEAK_RELEASE_COEFF = 25'd346
) (
   input  logic                    clock,
   input  logic                    reset,
   input  acg_pkg::acg_cmd_type    cmd,
   output acg_pkg::acg_status_type status,
   input  logic                    csr_we,
   input  logic [2:0]              csr_index,
   input  logic [24:0]             csr_wdata,
   input  logic [23:0]             sample_left,
   input  logic [23:0]             sample_right,
   output logic [23:0]             out_left,
   output logic [23:0]             out_right
);
   import acg_pkg::*;

   // Configuration and state
   logic [THR_W-1:0]   thr_ff;
   logic [GAIN_W-1:0]  makeup_ff;
   logic [RATIO_W-1:0] ratio_ff;
   logic [GAIN_W-1:0]  og_ff;
   logic [COEF_W-1:0]  attack_ff;
   logic [COEF_W-1:0]  release_ff;
   logic [THR_W-1:0]   gate_lvl_ff;
   logic [LEVEL_W-1:0] floor_ff, floor_in;
   logic [ENV_W-1:0]   env_ff, env_in;

   // Frame registers
   logic [SAMPLE_W-1:0] samp_l_ff, samp_r_ff;
   logic [LEVEL_W-1:0]  mag_l_ff, mag_r_ff;
   logic [LEVEL_W-1:0]  peak_ff;
   logic                bypass_ff;
   logic                above_ff;
   logic [41:0]         lvl_prod_ff;
   logic                fl_up_ff;
   logic [45:0]         fl_prod_ff;
   logic [50:0]         tgt_prod_ff;
   logic [36:0]         target_ff;
   logic [47:0]         gate_prod_ff;
   logic                gated_ff;
   logic [LEVEL_W-1:0]  rem_ff;
   logic [QUO_W-1:0]    quo_ff;
   logic                env_up_ff;
   logic [56:0]         env_prod_ff;
   logic [55:0]         g_prod_ff;
   logic [43:0]         pl_hi_ff, pl_lo_ff, pr_hi_ff, pr_lo_ff;
   logic [23:0]         out_l_ff, out_r_ff;

   // Combinational helpers
   logic [LEVEL_W-1:0]  mag_l, mag_r, peak_new;
   logic [LEVEL_W-1:0]  excess;
   logic                fl_down;
   logic [LEVEL_W-1:0]  fl_to;
   logic [LEVEL_W-1:0]  fl_diff;
   logic [21:0]         fl_coef;
   logic [26:0]         lvl;
   logic [26:0]         tgt_mul_a;
   logic [34:0]         tgt_raw;
   logic                gated;
   logic [51:0]         dividend;
   logic [LEVEL_W-1:0]  d_rem;
   logic [QUO_W-1:0]    d_quo;
   logic [LEVEL_W:0]    d_shift;
   logic                env_gt;
   logic [COEF_W-1:0]   coef_sel, coef;
   logic [ENV_W-1:0]    env_diff;
   logic [32:0]         env_step, env_new;
   logic [39:0]         g_total;
   logic [23:0]         scaled_l, scaled_r;

   assign status.bypass = (ratio_ff > UNITY_RATIO);

   // Saturate a scaled magnitude back to a signed sample
   function automatic logic [23:0] saturate(input logic [43:0] hi, input logic [43:0] lo,
                                            input logic neg);
      logic [63:0] p;
      logic [48:0] r;
      p = {hi, 20'd0} + {20'd0, lo};
      r = p[63:15];
      if (neg) begin
         saturate = (r > 49'h800000) ? 24'h800000 : (24'd0 - r[23:0]);
      end else begin
         saturate = (r > 49'h7FFFFF) ? 24'h7FFFFF : r[23:0];
      end
   endfunction

   // Peak of the incoming frame
   always_comb begin
      mag_l = magnitude(sample_left);
      mag_r = magnitude(sample_right);
      peak_new = PEAK_FLOOR;
      if (mag_l > peak_new) peak_new = mag_l;
      if (mag_r > peak_new) peak_new = mag_r;
   end

   // Excess over threshold and gate floor move
   always_comb begin
      excess  = peak_ff - {1'b0, thr_ff};
      fl_down = peak_ff < floor_ff;
      fl_to   = fl_down ? peak_ff : {1'b0, gate_lvl_ff};
      fl_diff = (fl_to >= floor_ff) ? (fl_to - floor_ff) : (floor_ff - fl_to);
      fl_coef = fl_down ? GATE_DOWN : GATE_UP;
   end

   // Target level and gate test
   always_comb begin
      lvl       = 27'(lvl_prod_ff[41:16]) + 27'(thr_ff);
      tgt_mul_a = above_ff ? lvl : 27'(peak_ff);
      tgt_raw   = tgt_prod_ff[50:16];
      gated     = {peak_ff, 24'd0} < gate_prod_ff;
      dividend  = gated ? 52'd0 : {target_ff, 15'd0};
   end

   // Four restoring division steps
   always_comb begin
      d_rem   = rem_ff;
      d_quo   = quo_ff;
      d_shift = '0;
      for (int i = 0; i < DIV_BITS; i++) begin
         d_shift = {d_rem, d_quo[QUO_W-1]};
         if (d_shift >= {1'b0, peak_ff}) begin
            d_shift = d_shift - {1'b0, peak_ff};
            d_quo   = {d_quo[QUO_W-2:0], 1'b1};
         end else begin
            d_quo   = {d_quo[QUO_W-2:0], 1'b0};
         end
         d_rem = d_shift[LEVEL_W-1:0];
      end
   end

   // Envelope smoothing
   always_comb begin
      env_gt = env_ff > quo_ff;
      if (gated_ff) begin
         coef_sel = env_gt ? PEAK_RELEASE_COEFF : PEAK_ATTACK_COEFF;
      end else begin
         coef_sel = env_gt ? attack_ff : release_ff;
      end
      coef     = (coef_sel > COEF_ONE) ? COEF_ONE : coef_sel;
      env_diff = env_gt ? (env_ff - quo_ff) : (quo_ff - env_ff);
      env_step = env_prod_ff[56:24];
      env_new  = env_up_ff ? (33'(env_ff) + env_step) : (33'(env_ff) - env_step);
      env_in   = (env_new >= 33'(ENV_CAP)) ? ENV_CAP : env_new[ENV_W-1:0];
      g_total  = g_prod_ff[55:16];
   end

   // Gate floor next value
   always_comb begin
      floor_in = floor_ff;
      if (csr_we && csr_index == REG_GATE) begin
         floor_in = {1'b0, csr_wdata[THR_W-1:0]};
      end else if (cmd.target) begin
         floor_in = fl_up_ff ? (floor_ff + 24'(fl_prod_ff[45:24]))
                             : (floor_ff - 24'(fl_prod_ff[45:24]));
      end
   end

   assign scaled_l = saturate(pl_hi_ff, pl_lo_ff, samp_l_ff[SAMPLE_W-1]);
   assign scaled_r = saturate(pr_hi_ff, pr_lo_ff, samp_r_ff[SAMPLE_W-1]);

   // Configuration registers and persistent state
   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff      <= THRESHOLD_RST;
         makeup_ff   <= MAKEUP_RST;
         ratio_ff    <= INV_RATIO_RST;
         og_ff       <= OUT_GAIN_RST;
         attack_ff   <= ATTACK_RST;
         release_ff  <= RELEASE_RST;
         gate_lvl_ff <= GATE_RST;
         floor_ff    <= {1'b0, GATE_RST};
         env_ff      <= ENV_ONE;
      end else begin
         floor_ff <= floor_in;
         if (cmd.env_upd) begin
            env_ff <= env_in;
         end
         if (csr_we) begin
            unique case (csr_index)
               REG_THRESHOLD: thr_ff      <= csr_wdata[THR_W-1:0];
               REG_MAKEUP:    makeup_ff   <= csr_wdata[GAIN_W-1:0];
               REG_INV_RATIO: ratio_ff    <= csr_wdata[RATIO_W-1:0];
               REG_OUT_GAIN:  og_ff       <= csr_wdata[GAIN_W-1:0];
               REG_ATTACK:    attack_ff   <= csr_wdata;
               REG_RELEASE:   release_ff  <= csr_wdata;
               REG_GATE:      gate_lvl_ff <= csr_wdata[THR_W-1:0];
               default: ;
            endcase
         end
      end
   end

   // Frame pipeline registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         samp_l_ff <= sample_left;
         samp_r_ff <= sample_right;
         mag_l_ff  <= mag_l;
         mag_r_ff  <= mag_r;
         peak_ff   <= peak_new;
         bypass_ff <= status.bypass;
      end
      if (cmd.level) begin
         above_ff    <= peak_ff > {1'b0, thr_ff};
         lvl_prod_ff <= excess * ratio_ff;
         fl_up_ff    <= fl_to >= floor_ff;
         fl_prod_ff  <= fl_diff * fl_coef;
      end
      if (cmd.target) begin
         tgt_prod_ff <= tgt_mul_a * makeup_ff;
      end
      if (cmd.gate) begin
         target_ff    <= (above_ff && 37'(tgt_raw) > TARGET_CAP) ? TARGET_CAP : 37'(tgt_raw);
         gate_prod_ff <= floor_ff * GATE_OPEN_FRAC;
      end
      if (cmd.div_load) begin
         gated_ff <= gated;
         rem_ff   <= 24'(dividend[51:32]);
         quo_ff   <= dividend[31:0];
      end
      if (cmd.div_step) begin
         rem_ff <= d_rem;
         quo_ff <= d_quo;
      end
      if (cmd.env_mul) begin
         env_up_ff   <= !env_gt;
         env_prod_ff <= env_diff * coef;
      end
      if (cmd.gain) begin
         g_prod_ff <= env_ff * og_ff;
      end
      if (cmd.scale) begin
         pl_hi_ff <= mag_l_ff * g_total[39:20];
         pl_lo_ff <= mag_l_ff * g_total[19:0];
         pr_hi_ff <= mag_r_ff * g_total[39:20];
         pr_lo_ff <= mag_r_ff * g_total[19:0];
      end
      if (cmd.finish) begin
         out_l_ff <= bypass_ff ? samp_l_ff : scaled_l;
         out_r_ff <= bypass_ff ? samp_r_ff : scaled_r;
      end
   end

   assign out_left  = out_l_ff;
   assign out_right = out_r_ff;

endmodule

// ===== rtl/audio_compressor_with_gate.sv =====
// Top level: stereo peak compressor with adaptive gate, controller plus datapath.
// The frame peak is formed in the accepting cycle. The frame then passes through
// eight steps for level, target, gate test, divider load, envelope multiply and
// update, gain and scaling; between divider load and envelope the shared radix-16
// divider forms target over peak, and the result load comes last. In bypass
// (inverse_ratio above unity) the frame goes from acceptance straight to the
// result load. A new frame is accepted as soon as the previous one has been loaded
// into the output register, even while that result still waits to be taken; the
// next frame then holds at its load until the output is free. Configuration must be
// written by the user only while no frame is in flight; the block does not enforce
// this. A write of gate_level also reloads the gate floor.
module audio_compressor_with_gate #(
   parameter logic [24:0] PEAK_ATTACK_COEFF  = 25'd353,
   parameter logic [24:0] PEAK_RELEASE_COEFF = 25'd346
) (
   input  logic        clock,
   input  logic        reset,
   acg_req_if.sink     req_frame,
   acg_rsp_if.source   rsp_frame,
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [24:0] csr_wdata
);
   import acg_pkg::*;

   acg_cmd_type    cmd;
   acg_status_type status;

   // Sequencer
   acg_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_frame.valid),
      .req_ready (req_frame.ready),
      .rsp_valid (rsp_frame.valid),
      .rsp_ready (rsp_frame.ready),
      .status    (status),
      .cmd       (cmd)
   );

   // Arithmetic and state
   acg_datapath #(
      .PEAK_ATTACK_COEFF  (PEAK_ATTACK_COEFF),
      .PEAK_RELEASE_COEFF (PEAK_RELEASE_COEFF)
   ) u_dp (
      .clock        (clock),
      .reset        (reset),
      .cmd          (cmd),
      .status       (status),
      .csr_we       (csr_we),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .sample_left  (req_frame.sample_left),
      .sample_right (req_frame.sample_right),
      .out_left     (rsp_frame.out_left),
      .out_right    (rsp_frame.out_right)
   );

endmodule
